// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LBPC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LBPC_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: rtl/lbpc_pkg.sv
package lbpc_pkg;

   localparam int TIMER_BITS     = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int PUSH_SLOTS     = 3;
   localparam int SETTLE_BITS    = 16;
   localparam int CMP_BITS       = (TIMER_BITS > SETTLE_BITS) ? TIMER_BITS : SETTLE_BITS;
   localparam int QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANGE_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_TICKS     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_STEP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_OPCODE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLAY_OPCODE      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PLAY_FOLDER      = 3'd5;

   typedef struct packed {
      logic       ms_tick;
      logic [9:0] volume_level_raw;
      logic [9:0] track_level_raw;
      logic       host_valid;
      logic [7:0] host_opcode;
      logic [7:0] host_param_hi;
      logic [7:0] host_param_lo;
   } req_item_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       frame_end;
      logic       run_end;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] cmd;
      logic [7:0] p1;
      logic [7:0] p2;
      logic       last;
   } frame_desc_type;

   typedef struct packed {
      logic [PUSH_SLOTS-1:0]                 valid;
      frame_desc_type [PUSH_SLOTS-1:0]       desc;
   } push_bundle_type;

   typedef struct packed {
      logic           valid;
      frame_desc_type desc;
   } queue_head_type;

endpackage

// File: rtl/level_band_to_player_command_core.sv
// Turns polling passes into player command frames. An item is taken in the cycle it is
// offered as long as the frame queue has three free entries, so items may follow each
// other in consecutive cycles; each pass yields zero to three ten-byte frames (volume,
// then track, then host), and the byte serializer sends one byte per cycle while the
// output is not stalled, so that serializer sets the sustained rate. Configuration
// writes are always ready and take effect in the next cycle.
module level_band_to_player_command_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lbpc_pkg::req_item_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output lbpc_pkg::rsp_item_type                rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lbpc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lbpc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import lbpc_pkg::*;

   push_bundle_type push;
   queue_head_type  head;
   logic            queue_ready;
   logic            pop;

   assign csr_ready = 1'b1;

   lbpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_ready (queue_ready),
      .push        (push)
   );

   lbpc_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .queue_ready (queue_ready),
      .head        (head),
      .pop         (pop)
   );

   lbpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/lbpc_front.sv
module lbpc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  lbpc_pkg::req_item_type                req_data,
   input  logic                                  csr_valid,
   input  logic [lbpc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lbpc_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  queue_ready,
   output lbpc_pkg::push_bundle_type             push
);
   import lbpc_pkg::*;

   localparam logic [3:0] VOL_STANDBY = 4'd11;
   localparam logic [3:0] VOL_DEAD    = 4'd12;
   localparam logic [2:0] TRK_STANDBY = 3'd0;
   localparam logic [2:0] TRK_TOP     = 3'd4;
   localparam logic [2:0] TRK_DEAD    = 3'd5;

   function automatic logic [3:0] volume_band_of(input logic [7:0] l);
      logic [3:0] b;
      b = VOL_DEAD;
      if (l > 8'd0 && l < 8'd20) begin
         b = VOL_STANDBY;
      end else if (l > 8'd221 && l < 8'd255) begin
         b = 4'd10;
      end else begin
         for (int k = 0; k < 10; k++) begin
            if (l > 8'(21 + 20 * k) && l < 8'(40 + 20 * k)) begin
               b = 4'(k);
            end
         end
      end
      return b;
   endfunction

   function automatic logic [2:0] track_band_of(input logic [7:0] l);
      logic [2:0] b;
      if (l > 8'd0 && l < 8'd50) begin
         b = TRK_STANDBY;
      end else if (l > 8'd51 && l < 8'd100) begin
         b = 3'd1;
      end else if (l > 8'd101 && l < 8'd150) begin
         b = 3'd2;
      end else if (l > 8'd151 && l < 8'd200) begin
         b = 3'd3;
      end else if (l > 8'd201 && l < 8'd255) begin
         b = 3'd4;
      end else begin
         b = TRK_DEAD;
      end
      return b;
   endfunction

   logic [7:0]             threshold_ff;
   logic [SETTLE_BITS-1:0] settle_ff;
   logic [2:0]             step_ff;
   logic [7:0]             vol_opcode_ff;
   logic [7:0]             play_opcode_ff;
   logic [7:0]             play_folder_ff;

   logic [7:0]            vol_held_ff, vol_held_in;
   logic [7:0]            trk_held_ff, trk_held_in;
   logic [TIMER_BITS-1:0] vol_elapsed_ff, vol_elapsed_in;
   logic [TIMER_BITS-1:0] trk_elapsed_ff, trk_elapsed_in;
   logic                  vol_pending_ff, vol_pending_in;
   logic                  trk_pending_ff, trk_pending_in;
   logic [3:0]            vol_band_ff, vol_band_in;
   logic [2:0]            trk_band_ff, trk_band_in;

   logic       accept;
   logic [7:0] vol_level, trk_level;
   logic [7:0] vol_diff, trk_diff;
   logic       vol_move, trk_move, vol_eval, trk_eval;
   logic       vol_pend_mid, trk_pend_mid;
   logic [3:0] vol_b;
   logic [2:0] trk_b;
   logic       vol_emit, trk_emit, host_emit;
   logic [7:0] vol_p2;

   assign accept    = req_valid & ~req_stall;
   assign req_stall = ~queue_ready;
   assign vol_level = req_data.volume_level_raw[9:2];
   assign trk_level = req_data.track_level_raw[9:2];

   always_comb begin
      vol_diff = (vol_level > vol_held_ff) ? vol_level - vol_held_ff : vol_held_ff - vol_level;
      trk_diff = (trk_level > trk_held_ff) ? trk_level - trk_held_ff : trk_held_ff - trk_level;
      vol_move = vol_diff > threshold_ff;
      trk_move = trk_diff > threshold_ff;

      vol_elapsed_in = vol_elapsed_ff;
      trk_elapsed_in = trk_elapsed_ff;
      if (req_data.ms_tick && vol_elapsed_ff != '1) begin
         vol_elapsed_in = vol_elapsed_ff + 1'b1;
      end
      if (req_data.ms_tick && trk_elapsed_ff != '1) begin
         trk_elapsed_in = trk_elapsed_ff + 1'b1;
      end
      if (vol_move) begin
         vol_elapsed_in = '0;
      end
      if (trk_move) begin
         trk_elapsed_in = '0;
      end

      vol_held_in  = vol_move ? vol_level : vol_held_ff;
      trk_held_in  = trk_move ? trk_level : trk_held_ff;
      vol_pend_mid = vol_move | vol_pending_ff;
      trk_pend_mid = trk_move | trk_pending_ff;

      vol_eval = vol_pend_mid &
                 (CMP_BITS'(vol_elapsed_in) >= CMP_BITS'(settle_ff));
      trk_eval = trk_pend_mid &
                 (CMP_BITS'(trk_elapsed_in) >= CMP_BITS'(settle_ff));
      vol_pending_in = vol_pend_mid & ~vol_eval;
      trk_pending_in = trk_pend_mid & ~trk_eval;

      vol_b = volume_band_of(vol_level);
      trk_b = track_band_of(trk_held_in);

      vol_band_in = vol_band_ff;
      trk_band_in = trk_band_ff;
      vol_emit    = 1'b0;
      trk_emit    = 1'b0;
      if (vol_eval && vol_b != VOL_DEAD && vol_b != vol_band_ff) begin
         vol_band_in = vol_b;
         vol_emit    = vol_b != VOL_STANDBY;
      end
      if (trk_eval && trk_b <= TRK_TOP && trk_b != trk_band_ff) begin
         trk_band_in = trk_b;
         trk_emit    = trk_b != TRK_STANDBY;
      end
      host_emit = req_data.host_valid;

      vol_p2 = 8'({4'd0, vol_b}) * 8'({5'd0, step_ff});

      push.valid[0]     = accept & vol_emit;
      push.valid[1]     = accept & trk_emit;
      push.valid[2]     = accept & host_emit;
      push.desc[0].cmd  = vol_opcode_ff;
      push.desc[0].p1   = 8'd0;
      push.desc[0].p2   = vol_p2;
      push.desc[0].last = ~trk_emit & ~host_emit;
      push.desc[1].cmd  = play_opcode_ff;
      push.desc[1].p1   = play_folder_ff;
      push.desc[1].p2   = {5'd0, trk_b};
      push.desc[1].last = ~host_emit;
      push.desc[2].cmd  = req_data.host_opcode;
      push.desc[2].p1   = req_data.host_param_hi;
      push.desc[2].p2   = req_data.host_param_lo;
      push.desc[2].last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= 8'd5;
         settle_ff      <= SETTLE_BITS'(1000);
         step_ff        <= 3'd3;
         vol_opcode_ff  <= 8'h06;
         play_opcode_ff <= 8'h0F;
         play_folder_ff <= 8'h01;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CHANGE_THRESHOLD: threshold_ff   <= csr_data[7:0];
            CSR_SETTLE_TICKS:     settle_ff      <= csr_data;
            CSR_VOLUME_STEP:      step_ff        <= csr_data[2:0];
            CSR_VOLUME_OPCODE:    vol_opcode_ff  <= csr_data[7:0];
            CSR_PLAY_OPCODE:      play_opcode_ff <= csr_data[7:0];
            CSR_PLAY_FOLDER:      play_folder_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vol_held_ff    <= 8'd1;
         trk_held_ff    <= 8'd1;
         vol_elapsed_ff <= '0;
         trk_elapsed_ff <= '0;
         vol_pending_ff <= 1'b1;
         trk_pending_ff <= 1'b1;
         vol_band_ff    <= VOL_STANDBY;
         trk_band_ff    <= TRK_STANDBY;
      end else if (accept) begin
         vol_held_ff    <= vol_held_in;
         trk_held_ff    <= trk_held_in;
         vol_elapsed_ff <= vol_elapsed_in;
         trk_elapsed_ff <= trk_elapsed_in;
         vol_pending_ff <= vol_pending_in;
         trk_pending_ff <= trk_pending_in;
         vol_band_ff    <= vol_band_in;
         trk_band_ff    <= trk_band_in;
      end
   end

endmodule

// File: rtl/lbpc_queue.sv
`include "assert_macros.svh"

module lbpc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  lbpc_pkg::push_bundle_type  push,
   output logic                       queue_ready,
   output lbpc_pkg::queue_head_type   head,
   input  logic                       pop
);
   import lbpc_pkg::*;

   function automatic logic [QPTR_BITS-1:0] ptr_add(input logic [QPTR_BITS-1:0] p,
                                                    input logic [1:0] k);
      logic [QPTR_BITS:0] s;
      s = (QPTR_BITS + 1)'(p) + (QPTR_BITS + 1)'(k);
      if (s >= (QPTR_BITS + 1)'(QUEUE_DEPTH)) begin
         s = s - (QPTR_BITS + 1)'(QUEUE_DEPTH);
      end
      return s[QPTR_BITS-1:0];
   endfunction

   frame_desc_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in;
   logic [QPTR_BITS-1:0] rd_ff, rd_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic [1:0]           off [PUSH_SLOTS];
   logic [1:0]           push_count;

   always_comb begin
      off[0]     = 2'd0;
      off[1]     = {1'b0, push.valid[0]};
      off[2]     = {1'b0, push.valid[0]} + {1'b0, push.valid[1]};
      push_count = off[2] + {1'b0, push.valid[2]};
      wr_in      = ptr_add(wr_ff, push_count);
      rd_in      = pop ? ptr_add(rd_ff, 2'd1) : rd_ff;
      count_in   = count_ff + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
   end

   assign queue_ready = count_ff <= QCNT_BITS'(QUEUE_DEPTH - PUSH_SLOTS);
   assign head.valid  = count_ff != '0;
   assign head.desc   = entry_ff[rd_ff];

   always_ff @(posedge clock) begin
      for (int j = 0; j < PUSH_SLOTS; j++) begin
         if (push.valid[j]) begin
            entry_ff[ptr_add(wr_ff, off[j])] <= push.desc[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `LBPC_ASSERT_ALWAYS(a_count_bound, count_ff <= QCNT_BITS'(QUEUE_DEPTH), "queue overfilled")
   `LBPC_ASSERT_IMPLIES(a_push_room, push.valid != '0, queue_ready, "push without room")
   `LBPC_ASSERT_IMPLIES(a_pop_nonempty, pop, count_ff != '0, "pop from empty queue")

endmodule

// File: rtl/lbpc_back.sv
`include "assert_macros.svh"

module lbpc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  lbpc_pkg::queue_head_type  head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lbpc_pkg::rsp_item_type    rsp_data
);
   import lbpc_pkg::*;

   localparam logic [3:0] POS_START    = 4'd0;
   localparam logic [3:0] POS_VERSION  = 4'd1;
   localparam logic [3:0] POS_LENGTH   = 4'd2;
   localparam logic [3:0] POS_CMD      = 4'd3;
   localparam logic [3:0] POS_FEEDBACK = 4'd4;
   localparam logic [3:0] POS_PARAM_HI = 4'd5;
   localparam logic [3:0] POS_PARAM_LO = 4'd6;
   localparam logic [3:0] POS_CHK_HI   = 4'd7;
   localparam logic [3:0] POS_CHK_LO   = 4'd8;
   localparam logic [3:0] POS_END      = 4'd9;

   localparam logic [7:0] BYTE_START    = 8'h7E;
   localparam logic [7:0] BYTE_VERSION  = 8'hFF;
   localparam logic [7:0] BYTE_LENGTH   = 8'h06;
   localparam logic [7:0] BYTE_FEEDBACK = 8'h01;
   localparam logic [7:0] BYTE_END      = 8'hEF;

   logic        active_ff, active_in;
   logic [3:0]  idx_ff, idx_in;
   logic [7:0]  cmd_ff, p1_ff, p2_ff;
   logic [15:0] chk_ff, chk_in;
   logic        last_ff;
   logic        take, done, free;
   logic [10:0] sum;

   always_comb begin
      take = active_ff & ~rsp_stall;
      done = take & (idx_ff == POS_END);
      free = ~active_ff | done;
      pop  = free & head.valid;
      active_in = pop | (active_ff & ~done);
      if (pop) begin
         idx_in = POS_START;
      end else if (take) begin
         idx_in = idx_ff + 4'd1;
      end else begin
         idx_in = idx_ff;
      end
      sum = 11'(BYTE_VERSION) + 11'(BYTE_LENGTH) + 11'(BYTE_FEEDBACK) +
            11'(head.desc.cmd) + 11'(head.desc.p1) + 11'(head.desc.p2);
      chk_in = 16'd0 - {5'd0, sum};
   end

   always_comb begin
      case (idx_ff)
         POS_START:    rsp_data.tx_byte = BYTE_START;
         POS_VERSION:  rsp_data.tx_byte = BYTE_VERSION;
         POS_LENGTH:   rsp_data.tx_byte = BYTE_LENGTH;
         POS_CMD:      rsp_data.tx_byte = cmd_ff;
         POS_FEEDBACK: rsp_data.tx_byte = BYTE_FEEDBACK;
         POS_PARAM_HI: rsp_data.tx_byte = p1_ff;
         POS_PARAM_LO: rsp_data.tx_byte = p2_ff;
         POS_CHK_HI:   rsp_data.tx_byte = chk_ff[15:8];
         POS_CHK_LO:   rsp_data.tx_byte = chk_ff[7:0];
         POS_END:      rsp_data.tx_byte = BYTE_END;
         default:      rsp_data.tx_byte = 8'h00;
      endcase
      rsp_data.frame_end = idx_ff == POS_END;
      rsp_data.run_end   = (idx_ff == POS_END) & last_ff;
   end

   assign rsp_valid = active_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff  <= head.desc.cmd;
         p1_ff   <= head.desc.p1;
         p2_ff   <= head.desc.p2;
         chk_ff  <= chk_in;
         last_ff <= head.desc.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= POS_START;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   `LBPC_ASSERT_IMPLIES(a_idle_after_end, $fell(active_ff), $past(done), "frame cut short")
   `LBPC_ASSERT_IMPLIES(a_idx_range, active_ff, idx_ff <= POS_END, "byte index out of frame")

endmodule
